// File: rtl/encoder_and_button_input_qualifier_defines.svh
// Assertion macros used by the checker file of the input qualifier.
`ifndef ENCODER_AND_BUTTON_INPUT_QUALIFIER_DEFINES_SVH
`define ENCODER_AND_BUTTON_INPUT_QUALIFIER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define EBIQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define EBIQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/ebiq_pkg.sv
// Types, constants and helper functions of the encoder and button input qualifier.
package ebiq_pkg;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_PRESS       = 3'd1,
    EV_HOLD        = 3'd2,
    EV_BRIGHT_UP   = 3'd3,
    EV_BRIGHT_DOWN = 3'd4,
    EV_SELECT      = 3'd5,
    EV_BACK        = 3'd6
  } ebiq_event_e;

  localparam logic [1:0] CFG_REVERSE = 2'd0;
  localparam logic [1:0] CFG_HOLD    = 2'd1;
  localparam logic [1:0] CFG_SET_IDX = 2'd2;

  localparam logic signed [7:0] DETENT_THRESHOLD = 8'sd3;
  localparam logic [4:0]        HOLD_COUNT_RESET = 5'd20;
  localparam logic [4:0]        HELD_MAX         = 5'd31;
  localparam logic [1:0]        PINS_BOTH_HIGH   = 2'b11;
  localparam logic [2:0]        BTN_ALL_RELEASED = 3'b111;
  localparam logic [1:0]        SET_IDX_NONE     = 2'd3;

  typedef struct packed {
    logic       reverse_direction;
    logic [4:0] hold_count;
    logic [1:0] set_button_index;
  } ebiq_cfg_t;

  typedef struct packed {
    ebiq_event_e       event_res;
    logic [2:0]        buttons;
    logic signed [7:0] detent_delta;
  } ebiq_res_t;

  // Quadrature step for the index {previous B, previous A, current B, current A}.
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] step;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  step = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: step = -2'sd1;
      default:                  step = 2'sd0;
    endcase
    return step;
  endfunction

  function automatic logic signed [7:0] sat8(input logic signed [8:0] v);
    logic signed [7:0] r;
    if (v > 9'sd127) begin
      r = 8'sd127;
    end else if (v < -9'sd128) begin
      r = -8'sd128;
    end else begin
      r = $signed(v[7:0]);
    end
    return r;
  endfunction

endpackage

// File: rtl/ebiq_in_if.sv
// Input channel: encoder pin changes and sampling ticks.
interface ebiq_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] encoder_pins;
  logic [2:0] button_levels;

  modport source (output valid, output kind, output encoder_pins, output button_levels,
                  input ready);
  modport sink (input valid, input kind, input encoder_pins, input button_levels,
                output ready);
endinterface

// File: rtl/ebiq_out_if.sv
// Output channel: one qualified event item per sampling tick.
interface ebiq_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        event_res;
  logic [2:0]        buttons;
  logic signed [7:0] detent_delta;

  modport source (output valid, output event_res, output buttons, output detent_delta,
                  input ready);
  modport sink (input valid, input event_res, input buttons, input detent_delta,
                output ready);
endinterface

// File: rtl/ebiq_enc.sv
// Quadrature decoder with step accumulation and saturating detent tick count.
module ebiq_enc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [1:0]            pins_i,
  input  logic                  clear_i,
  input  ebiq_pkg::ebiq_cfg_t   cfg_i,
  output logic signed [7:0]     tick_total_o
);

  logic [1:0]        prev_q, prev_d;
  logic signed [7:0] step_sum_q, step_sum_d;
  logic signed [7:0] tick_q, tick_d;
  logic signed [1:0] step;
  logic signed [7:0] sum_sat;
  logic signed [7:0] tick_inc, tick_dec;

  assign step     = ebiq_pkg::quad_step({prev_q, pins_i});
  assign sum_sat  = ebiq_pkg::sat8({step_sum_q[7], step_sum_q} + {{7{step[1]}}, step});
  assign tick_inc = ebiq_pkg::sat8({tick_q[7], tick_q} + 9'sd1);
  assign tick_dec = ebiq_pkg::sat8({tick_q[7], tick_q} - 9'sd1);

  always_comb begin
    prev_d     = prev_q;
    step_sum_d = step_sum_q;
    tick_d     = tick_q;
    if (clear_i) begin
      tick_d = 8'sd0;
    end else if (fire_i) begin
      prev_d     = pins_i;
      step_sum_d = sum_sat;
      // A detent registers only at the rest position with both pins high.
      if (pins_i == ebiq_pkg::PINS_BOTH_HIGH) begin
        if (sum_sat > ebiq_pkg::DETENT_THRESHOLD) begin
          tick_d     = cfg_i.reverse_direction ? tick_dec : tick_inc;
          step_sum_d = 8'sd0;
        end else if (sum_sat < -ebiq_pkg::DETENT_THRESHOLD) begin
          tick_d     = cfg_i.reverse_direction ? tick_inc : tick_dec;
          step_sum_d = 8'sd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= ebiq_pkg::PINS_BOTH_HIGH;
      step_sum_q <= 8'sd0;
      tick_q     <= 8'sd0;
    end else begin
      prev_q     <= prev_d;
      step_sum_q <= step_sum_d;
      tick_q     <= tick_d;
    end
  end

  assign tick_total_o = tick_q;

endmodule

// File: rtl/ebiq_btn.sv
// Button press and hold qualification and event selection on a sampling tick.
module ebiq_btn (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [2:0]            levels_i,
  input  logic signed [7:0]     tick_total_i,
  input  ebiq_pkg::ebiq_cfg_t   cfg_i,
  output ebiq_pkg::ebiq_res_t   res_o
);

  logic [2:0] prev_btn_q, prev_btn_d;
  logic [4:0] held_q, held_d;
  logic [4:0] held_inc;
  logic [2:0] down;
  logic [2:0] released;
  logic       set_down;

  assign down     = ~levels_i;
  assign released = ~prev_btn_q & levels_i;
  assign set_down = (cfg_i.set_button_index != ebiq_pkg::SET_IDX_NONE) &&
                    down[cfg_i.set_button_index];
  assign held_inc = (held_q < ebiq_pkg::HELD_MAX) ? held_q + 5'd1 : held_q;

  always_comb begin
    prev_btn_d         = prev_btn_q;
    held_d             = held_q;
    res_o.event_res    = ebiq_pkg::EV_NONE;
    res_o.buttons      = 3'd0;
    res_o.detent_delta = tick_total_i;
    if (tick_total_i != 8'sd0) begin
      // Encoder motion overrides buttons and suppresses the following release.
      held_d = cfg_i.hold_count;
      if (down != 3'd0) begin
        res_o.detent_delta = 8'sd0;
        if (set_down) begin
          res_o.event_res = (tick_total_i > 8'sd0) ? ebiq_pkg::EV_BRIGHT_UP
                                                   : ebiq_pkg::EV_BRIGHT_DOWN;
        end else begin
          res_o.event_res = (tick_total_i > 8'sd0) ? ebiq_pkg::EV_SELECT
                                                   : ebiq_pkg::EV_BACK;
        end
      end
    end else if (held_q >= cfg_i.hold_count) begin
      if (levels_i == ebiq_pkg::BTN_ALL_RELEASED) begin
        held_d = 5'd0;
      end
      prev_btn_d = levels_i;
    end else if (levels_i != prev_btn_q) begin
      held_d        = 5'd0;
      prev_btn_d    = levels_i;
      res_o.buttons = released;
      if (released != 3'd0) begin
        res_o.event_res = ebiq_pkg::EV_PRESS;
      end
    end else if (levels_i != ebiq_pkg::BTN_ALL_RELEASED) begin
      held_d = held_inc;
      if (held_inc == cfg_i.hold_count) begin
        res_o.event_res = ebiq_pkg::EV_HOLD;
        res_o.buttons   = down;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_btn_q <= ebiq_pkg::BTN_ALL_RELEASED;
      held_q     <= 5'd0;
    end else if (fire_i) begin
      prev_btn_q <= prev_btn_d;
      held_q     <= held_d;
    end
  end

endmodule

// File: rtl/encoder_and_button_input_qualifier.sv
// Top level of the encoder and button input qualifier.
//
//   channel  direction  item
//   in_ch    sink       kind, encoder_pins, button_levels
//   out_ch   source     event_res, buttons, detent_delta
//   cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// An item is taken into an input register and processed from there, one item per
// cycle unless a sampling tick there waits on a stalled output register.
// A tick's result is valid after the input register and the output register.
// Reset is asynchronous and active low; it clears the valid flags but not the item data.
// A stalled output stops only sampling ticks; pin changes pass until a tick waits in the input register.
module encoder_and_button_input_qualifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  ebiq_in_if.sink     in_ch,
  ebiq_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [4:0]  cfg_data_i
);

  ebiq_pkg::ebiq_cfg_t cfg_q;
  ebiq_pkg::ebiq_res_t tick_res;
  ebiq_pkg::ebiq_res_t res_q;

  logic              stage_vld_q;
  logic              kind_q;
  logic [1:0]        pins_q;
  logic [2:0]        levels_q;
  logic              out_vld_q;
  logic              advance;
  logic              enc_fire;
  logic              tick_fire;
  logic signed [7:0] tick_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverse_direction <= 1'b0;
      cfg_q.hold_count        <= ebiq_pkg::HOLD_COUNT_RESET;
      cfg_q.set_button_index  <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ebiq_pkg::CFG_REVERSE: cfg_q.reverse_direction <= cfg_data_i[0];
        ebiq_pkg::CFG_HOLD:    cfg_q.hold_count        <= cfg_data_i;
        ebiq_pkg::CFG_SET_IDX: cfg_q.set_button_index  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Pin changes produce no item, so they never wait on the output register.
  assign advance     = stage_vld_q && (!kind_q || !out_vld_q || out_ch.ready);
  assign in_ch.ready = !stage_vld_q || advance;
  assign enc_fire    = advance && !kind_q;
  assign tick_fire   = advance && kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      stage_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_q   <= in_ch.kind;
      pins_q   <= in_ch.encoder_pins;
      levels_q <= in_ch.button_levels;
    end
  end

  ebiq_enc u_enc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (enc_fire),
    .pins_i       (pins_q),
    .clear_i      (tick_fire),
    .cfg_i        (cfg_q),
    .tick_total_o (tick_total)
  );

  ebiq_btn u_btn (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (tick_fire),
    .levels_i     (levels_q),
    .tick_total_i (tick_total),
    .cfg_i        (cfg_q),
    .res_o        (tick_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (tick_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      res_q <= tick_res;
    end
  end

  assign out_ch.valid        = out_vld_q;
  assign out_ch.event_res    = res_q.event_res;
  assign out_ch.buttons      = res_q.buttons;
  assign out_ch.detent_delta = res_q.detent_delta;

endmodule

// File: rtl/ebiq_checker.sv
// Port-level checks of the input qualifier and their attachment to the top level.
`include "encoder_and_button_input_qualifier_defines.svh"

module ebiq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [2:0]        event_res_i,
  input logic [2:0]        buttons_i,
  input logic signed [7:0] detent_delta_i
);

  logic        nav_event;
  logic        btn_event;
  logic        no_mask;
  logic        no_delta;
  logic [13:0] out_item;

  assign nav_event = (event_res_i == ebiq_pkg::EV_BRIGHT_UP) ||
                     (event_res_i == ebiq_pkg::EV_BRIGHT_DOWN) ||
                     (event_res_i == ebiq_pkg::EV_SELECT) ||
                     (event_res_i == ebiq_pkg::EV_BACK);
  assign btn_event = (event_res_i == ebiq_pkg::EV_PRESS) ||
                     (event_res_i == ebiq_pkg::EV_HOLD);
  assign no_mask   = (buttons_i == 3'd0);
  assign no_delta  = (detent_delta_i == 8'sd0);
  assign out_item  = {event_res_i, buttons_i, detent_delta_i};

  `EBIQ_ASSERT(a_out_valid_holds, out_valid_i && !out_ready_i |=> out_valid_i, "out item dropped")
  `EBIQ_ASSERT(a_out_item_holds, out_valid_i && !out_ready_i |=> $stable(out_item), "out item changed")
  `EBIQ_ASSERT(a_nav_clean, out_valid_i && nav_event |-> no_mask && no_delta, "navigation item dirty")
  `EBIQ_ASSERT(a_btn_mask, out_valid_i && btn_event |-> !no_mask && no_delta, "button item without mask")
  `EBIQ_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_i || rst_ni, "out item during reset")

endmodule

bind encoder_and_button_input_qualifier ebiq_checker u_ebiq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .event_res_i    (out_ch.event_res),
  .buttons_i      (out_ch.buttons),
  .detent_delta_i (out_ch.detent_delta)
);

// File: dv/encoder_and_button_input_qualifier_tb.sv
// Self-checking testbench of the encoder and button input qualifier: directed and random items.
module encoder_and_button_input_qualifier_tb;

  localparam bit          KIND_PINS       = 1'b0;
  localparam bit          KIND_TICK       = 1'b1;
  localparam bit          TURN_CW         = 1'b1;
  localparam bit          TURN_CCW        = 1'b0;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int          MAX_REPORTS     = 10;

  typedef struct packed {
    logic       kind;
    logic [1:0] pins;
    logic [2:0] levels;
  } qual_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b1;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [4:0] cfg_data_i;

  ebiq_in_if  in_ch ();
  ebiq_out_if out_ch ();

  encoder_and_button_input_qualifier u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Copy of the block's registers and state, advanced once per accepted item.
  logic              cfg_reverse  = 1'b0;
  logic [4:0]        cfg_hold     = ebiq_pkg::HOLD_COUNT_RESET;
  logic [1:0]        cfg_set_idx  = 2'd0;
  logic [1:0]        enc_prev     = ebiq_pkg::PINS_BOTH_HIGH;
  logic signed [7:0] step_acc     = '0;
  logic signed [7:0] detent_total = '0;
  logic [2:0]        last_buttons = ebiq_pkg::BTN_ALL_RELEASED;
  logic [4:0]        down_ticks   = '0;

  qual_item_t          input_items_q[$];
  ebiq_pkg::ebiq_res_t pending_events_q[$];
  qual_item_t          offered;
  ebiq_pkg::ebiq_res_t predicted;
  ebiq_pkg::ebiq_res_t oldest_event;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          send_gap;
  int          recv_gap;
  int          hold_off_left;
  bit          hold_off_armed = 1'b0;
  int          fault_count = 0;
  int          items_made = 0;
  logic [1:0]  gen_pins = ebiq_pkg::PINS_BOTH_HIGH;
  int unsigned cycle_count = 0;

  function automatic int pin_step(input logic [1:0] prev, input logic [1:0] cur);
    case ({prev, cur})
      4'b1110, 4'b1000, 4'b0001, 4'b0111: return 1;
      4'b1101, 4'b0100, 4'b0010, 4'b1011: return -1;
      default:                            return 0;
    endcase
  endfunction

  function automatic logic signed [7:0] clamp8(input int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return 8'h80;
    return 8'(v);
  endfunction

  // Returns 1 when the item yields an event item, which is then placed in r.
  function automatic bit qualify_item(input qual_item_t it, output ebiq_pkg::ebiq_res_t r);
    logic [2:0] cur;
    logic [2:0] down;
    bit         set_down;
    int         dir;
    r.event_res    = ebiq_pkg::EV_NONE;
    r.buttons      = '0;
    r.detent_delta = detent_total;
    if (it.kind == KIND_PINS) begin
      dir      = cfg_reverse ? -1 : 1;
      step_acc = clamp8(int'(step_acc) + pin_step(enc_prev, it.pins));
      enc_prev = it.pins;
      if (it.pins == ebiq_pkg::PINS_BOTH_HIGH) begin
        if (step_acc > ebiq_pkg::DETENT_THRESHOLD) begin
          detent_total = clamp8(int'(detent_total) + dir);
          step_acc     = '0;
        end else if (step_acc < -ebiq_pkg::DETENT_THRESHOLD) begin
          detent_total = clamp8(int'(detent_total) - dir);
          step_acc     = '0;
        end
      end
      return 1'b0;
    end
    cur = it.levels;
    if (detent_total != 0) begin
      // A turn with a button down becomes a navigation or brightness code; the
      // hold counter is parked so the release that follows is swallowed.
      down       = ~cur;
      down_ticks = cfg_hold;
      if (down != 3'b000) begin
        set_down = (cfg_set_idx != ebiq_pkg::SET_IDX_NONE) &&
                   (((down >> cfg_set_idx) & 3'b001) != 3'b000);
        r.detent_delta = '0;
        if (set_down) begin
          r.event_res = (detent_total > 0) ? ebiq_pkg::EV_BRIGHT_UP : ebiq_pkg::EV_BRIGHT_DOWN;
        end else begin
          r.event_res = (detent_total > 0) ? ebiq_pkg::EV_SELECT : ebiq_pkg::EV_BACK;
        end
      end
    end else if (down_ticks >= cfg_hold) begin
      if (cur == ebiq_pkg::BTN_ALL_RELEASED) down_ticks = '0;
      last_buttons = cur;
    end else if (cur != last_buttons) begin
      down_ticks   = '0;
      r.buttons    = ~last_buttons & cur;
      last_buttons = cur;
      if (r.buttons != 3'b000) r.event_res = ebiq_pkg::EV_PRESS;
    end else if (cur != ebiq_pkg::BTN_ALL_RELEASED) begin
      if (down_ticks < ebiq_pkg::HELD_MAX) down_ticks++;
      if (down_ticks == cfg_hold) begin
        r.event_res = ebiq_pkg::EV_HOLD;
        r.buttons   = ~cur;
      end
    end
    detent_total = '0;
    return 1'b1;
  endfunction

  // No gap unless the roll falls under idle_pct; of the gaps, most are short and a few are long.
  function automatic int pick_gap(input int idle_pct);
    int roll;
    if ($urandom_range(99) >= idle_pct) return 0;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(3, 1);
    if (roll < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid         <= 1'b0;
      in_ch.kind          <= KIND_TICK;
      in_ch.encoder_pins  <= ebiq_pkg::PINS_BOTH_HIGH;
      in_ch.button_levels <= ebiq_pkg::BTN_ALL_RELEASED;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (qualify_item(offered, predicted)) pending_events_q.push_back(predicted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (input_items_q.size() != 0) begin
          offered = input_items_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.kind          <= offered.kind;
          in_ch.encoder_pins  <= offered.pins;
          in_ch.button_levels <= offered.levels;
          send_gap = pick_gap(send_idle_pct);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap      = 0;
      hold_off_left = 0;
    end else if (hold_off_left > 0) begin
      hold_off_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_off_armed) begin
      hold_off_armed = 1'b0;
      hold_off_left  = HOLD_OFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      recv_gap = pick_gap(recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_events_q.size() == 0) begin
        note_fault($sformatf("unexpected event item: event %0d buttons %b diff %0d",
                             out_ch.event_res, out_ch.buttons, out_ch.detent_delta));
      end else begin
        oldest_event = pending_events_q.pop_front();
        if (out_ch.event_res !== oldest_event.event_res ||
            out_ch.buttons !== oldest_event.buttons ||
            out_ch.detent_delta !== oldest_event.detent_delta) begin
          note_fault($sformatf({"event item mismatch: expected event %0d buttons %b diff %0d,",
                                " got event %0d buttons %b diff %0d"},
                               oldest_event.event_res, oldest_event.buttons,
                               oldest_event.detent_delta, out_ch.event_res, out_ch.buttons,
                               out_ch.detent_delta));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_pins(input logic [1:0] pins);
    qual_item_t it;
    it.kind   = KIND_PINS;
    it.pins   = pins;
    it.levels = 3'($urandom_range(7));
    input_items_q.push_back(it);
    gen_pins = pins;
    items_made++;
  endtask

  task automatic push_tick(input logic [2:0] levels);
    qual_item_t it;
    it.kind   = KIND_TICK;
    it.pins   = 2'($urandom_range(3));
    it.levels = levels;
    input_items_q.push_back(it);
    items_made++;
  endtask

  // One full quadrature cycle that ends with both pins high.
  task automatic push_detent(input bit cw);
    if (gen_pins != ebiq_pkg::PINS_BOTH_HIGH) push_pins(ebiq_pkg::PINS_BOTH_HIGH);
    if (cw) begin
      push_pins(2'b10);
      push_pins(2'b00);
      push_pins(2'b01);
    end else begin
      push_pins(2'b01);
      push_pins(2'b00);
      push_pins(2'b10);
    end
    push_pins(ebiq_pkg::PINS_BOTH_HIGH);
  endtask

  // Contact bounce: one step away from the rest position and straight back.
  task automatic push_bounce();
    if (gen_pins != ebiq_pkg::PINS_BOTH_HIGH) push_pins(ebiq_pkg::PINS_BOTH_HIGH);
    push_pins($urandom_range(1) ? 2'b10 : 2'b01);
    push_pins(ebiq_pkg::PINS_BOTH_HIGH);
  endtask

  task automatic random_episode();
    int         pick;
    int         n;
    int         turn_at;
    bit         cw;
    logic [2:0] pattern;
    pick = $urandom_range(99);
    if (pick < 40) begin
      n  = $urandom_range(3, 1);
      cw = 1'($urandom_range(1));
      repeat (n) begin
        if ($urandom_range(4) == 0) push_bounce();
        push_detent(cw);
      end
      push_tick($urandom_range(1) ? ebiq_pkg::BTN_ALL_RELEASED : 3'($urandom_range(7)));
    end else if (pick < 75) begin
      // A button pattern held for a while, sometimes with a turn in the middle.
      pattern = 3'($urandom_range(6));
      n       = $urandom_range(int'(cfg_hold) + 3, 1);
      turn_at = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        if (i == turn_at) push_detent(1'($urandom_range(1)));
        push_tick(pattern);
      end
      push_tick(ebiq_pkg::BTN_ALL_RELEASED);
    end else if (pick < 90) begin
      n = $urandom_range(6, 1);
      repeat (n) push_pins(2'($urandom_range(3)));
      push_tick(3'($urandom_range(7)));
    end else begin
      push_tick(3'($urandom_range(7)));
    end
  endtask

  task automatic set_config(input bit rev, input logic [4:0] hold, input logic [1:0] sidx);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ebiq_pkg::CFG_REVERSE;
    cfg_data_i <= 5'(rev);
    @(posedge clk_i);
    cfg_idx_i  <= ebiq_pkg::CFG_HOLD;
    cfg_data_i <= hold;
    @(posedge clk_i);
    cfg_idx_i  <= ebiq_pkg::CFG_SET_IDX;
    cfg_data_i <= 5'(sidx);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_reverse = rev;
    cfg_hold    = hold;
    cfg_set_idx = sidx;
  endtask

  // Waits until every offered item is taken and every event item has arrived.
  task automatic drain();
    while (input_items_q.size() != 0 || in_ch.valid || pending_events_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input bit rev, input logic [4:0] hold, input logic [1:0] sidx,
                           input int send_pct, input int recv_pct, input int n_items,
                           input bit long_hold_off);
    int goal;
    set_config(rev, hold, sidx);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (long_hold_off) hold_off_armed = 1'b1;
    goal = items_made + n_items;
    while (items_made < goal) random_episode();
    drain();
  endtask

  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= ebiq_pkg::CFG_REVERSE;
    cfg_data_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(1'b0, 5'd2, 2'd0);
    @(negedge clk_i);
    push_tick(ebiq_pkg::BTN_ALL_RELEASED);
    push_detent(TURN_CW);
    push_tick(ebiq_pkg::BTN_ALL_RELEASED);
    // Turn with the set button down, then the release after a turn reports nothing.
    push_detent(TURN_CCW);
    push_tick(3'b110);
    push_tick(ebiq_pkg::BTN_ALL_RELEASED);
    push_detent(TURN_CW);
    push_tick(3'b101);
    push_tick(ebiq_pkg::BTN_ALL_RELEASED);
    push_tick(3'b011);
    push_tick(ebiq_pkg::BTN_ALL_RELEASED);
    // All buttons down long enough to hold, then kept down past the hold.
    repeat (4) push_tick(3'b000);
    push_tick(ebiq_pkg::BTN_ALL_RELEASED);
    drain();

    run_phase(1'b1, 5'd1,  2'd1, 30, 30, 70, 1'b0);
    run_phase(1'b0, 5'd31, 2'd2, 0,  0,  70, 1'b0);
    run_phase(1'b1, 5'd0,  ebiq_pkg::SET_IDX_NONE, 50, 50, 60, 1'b0);
    run_phase(1'b0, 5'd3,  2'd0, 10, 20, 75, 1'b1);
    run_phase(1'b1, 5'd20, 2'd2, 60, 10, 70, 1'b0);
    run_phase(1'b0, 5'd2,  2'd1, 20, 60, 65, 1'b0);

    // Enough detents between two ticks to drive the total into its upper limit.
    set_config(1'b0, 5'd4, 2'd0);
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (129) push_detent(TURN_CW);
    push_tick(ebiq_pkg::BTN_ALL_RELEASED);
    drain();

    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
